FILE: design/bsct_pkg.sv
// Package: event codes, time and flag types, and BCD digit step functions for the timer.
package bsct_pkg;

    // Event codes carried on req_type
    typedef enum logic [3:0] {
        REQ_TICK     = 4'd0,
        REQ_CLEAR    = 4'd1,
        REQ_PAUSE    = 4'd2,
        REQ_RESUME   = 4'd3,
        REQ_TOGGLE   = 4'd4,
        REQ_SEC_INC  = 4'd5,
        REQ_SEC_DEC  = 4'd6,
        REQ_MIN_INC  = 4'd7,
        REQ_MIN_DEC  = 4'd8,
        REQ_HOUR_ADJ = 4'd9
    } t_req;

    // Six BCD digits of HH:MM:SS
    typedef struct packed {
        logic [1:0] h10;
        logic [3:0] h1;
        logic [2:0] m10;
        logic [3:0] m1;
        logic [2:0] s10;
        logic [3:0] s1;
    } t_time;

    // Run, mode and alarm flags
    typedef struct packed {
        logic running;
        logic down;
        logic alarm;
    } t_flags;

    // Digit constants
    localparam logic [3:0] UNITS_MAX  = 4'd9;
    localparam logic [2:0] TENS_MAX   = 3'd5;
    localparam logic [3:0] HOUR1_TOP  = 4'd4;
    localparam logic [3:0] HOUR1_LAST = 4'd3;
    localparam logic [1:0] HOUR10_TOP = 2'd2;

    function automatic logic is_zero(input t_time t);
        return (t.s1 == 4'd0) && (t.s10 == 3'd0) && (t.m1 == 4'd0) &&
               (t.m10 == 3'd0) && (t.h1 == 4'd0) && (t.h10 == 2'd0);
    endfunction

    function automatic logic is_24(input t_time t);
        return (t.h1 == HOUR1_TOP) && (t.h10 == HOUR10_TOP);
    endfunction

    function automatic t_time time_24();
        t_time t;
        t     = '0;
        t.h1  = HOUR1_TOP;
        t.h10 = HOUR10_TOP;
        return t;
    endfunction

    function automatic t_time hours_up(input t_time t);
        t_time r;
        r = t;
        if ((t.h10 != HOUR10_TOP && t.h1 != UNITS_MAX) ||
            (t.h10 == HOUR10_TOP && t.h1 != HOUR1_TOP)) begin
            r.h1 = t.h1 + 4'd1;
        end else begin
            r.h1 = 4'd0;
            if (t.h10 != HOUR10_TOP) begin
                r.h10 = t.h10 + 2'd1;
            end else begin
                r.h10 = 2'd0;
            end
        end
        return r;
    endfunction

    function automatic t_time minutes_up(input t_time t);
        t_time r;
        r = t;
        if (t.m1 == UNITS_MAX) begin
            r.m1 = 4'd0;
            if (t.m10 == TENS_MAX) begin
                r.m10 = 3'd0;
                r     = hours_up(r);
            end else begin
                r.m10 = t.m10 + 3'd1;
            end
        end else begin
            r.m1 = t.m1 + 4'd1;
        end
        return r;
    endfunction

    function automatic t_time seconds_up(input t_time t);
        t_time r;
        r = t;
        if (t.s1 == UNITS_MAX) begin
            r.s1 = 4'd0;
            if (t.s10 == TENS_MAX) begin
                r.s10 = 3'd0;
                r     = minutes_up(r);
            end else begin
                r.s10 = t.s10 + 3'd1;
            end
        end else begin
            r.s1 = t.s1 + 4'd1;
        end
        return r;
    endfunction

    function automatic t_time hours_down(input t_time t);
        t_time r;
        r = t;
        if (t.h1 != 4'd0) begin
            r.h1 = t.h1 - 4'd1;
        end else if (t.h10 != 2'd0) begin
            // borrow from the tens digit
            r.h10 = t.h10 - 2'd1;
            r.h1  = UNITS_MAX;
        end
        return r;
    endfunction

    function automatic t_time minutes_down(input t_time t);
        t_time r;
        r = t;
        if (t.m1 == 4'd0) begin
            r.m1 = UNITS_MAX;
            if (t.m10 == 3'd0) begin
                r.m10 = TENS_MAX;
                r     = hours_down(r);
            end else begin
                r.m10 = t.m10 - 3'd1;
            end
        end else begin
            r.m1 = t.m1 - 4'd1;
        end
        return r;
    endfunction

    function automatic t_time seconds_down(input t_time t);
        t_time r;
        r = t;
        if (t.s1 == 4'd0) begin
            r.s1 = UNITS_MAX;
            if (t.s10 == 3'd0) begin
                r.s10 = TENS_MAX;
                r     = minutes_down(r);
            end else begin
                r.s10 = t.s10 - 3'd1;
            end
        end else begin
            r.s1 = t.s1 - 4'd1;
        end
        return r;
    endfunction

endpackage

FILE: design/bcd_stopwatch_countdown_timer_top.sv
// Top level of the BCD HH:MM:SS stopwatch and countdown timer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  event   | in        | i_valid / o_stall    | i_req_type, i_hour_down
//  result  | out       | o_valid / i_stall    | o_sec_units .. o_hour_tens, o_alarm_on,
//          |           |                      | o_is_running, o_count_down
//
// One event is taken every cycle while o_stall is low; each result passes through the event
// register, then the result register, and is set by the combinational digit carry/borrow logic.
// Reset (i_rst_n low, synchronous) clears the digits and the alarm, sets running and
// up mode, and empties both registers.
// A stalled result holds in the result register; the event register keeps taking a
// transfer as long as the result register can move on.
module bcd_stopwatch_countdown_timer_top import bsct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_req_type,
    input  logic       i_hour_down,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_sec_units,
    output logic [2:0] o_sec_tens,
    output logic [3:0] o_min_units,
    output logic [2:0] o_min_tens,
    output logic [3:0] o_hour_units,
    output logic [1:0] o_hour_tens,
    output logic       o_alarm_on,
    output logic       o_is_running,
    output logic       o_count_down
);

    logic   r_in_valid;
    t_req   r_req;
    logic   r_hdown;
    logic   r_out_valid;
    t_time  r_out_time;
    t_flags r_out_flags;
    logic   out_free;
    logic   step;
    t_time  nxt_time;
    t_flags nxt_flags;

    // Result register can load when empty or being taken
    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // Event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req   <= t_req'(i_req_type);
            r_hdown <= i_hour_down;
        end
    end

    bsct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_req   (r_req),
        .i_hdown (r_hdown),
        .o_time  (nxt_time),
        .o_flags (nxt_flags)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_time  <= nxt_time;
            r_out_flags <= nxt_flags;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sec_units  = r_out_time.s1;
    assign o_sec_tens   = r_out_time.s10;
    assign o_min_units  = r_out_time.m1;
    assign o_min_tens   = r_out_time.m10;
    assign o_hour_units = r_out_time.h1;
    assign o_hour_tens  = r_out_time.h10;
    assign o_alarm_on   = r_out_flags.alarm;
    assign o_is_running = r_out_flags.running;
    assign o_count_down = r_out_flags.down;

`ifndef SYNTHESIS
    // Alarm only shows in down mode
    a_alarm_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_alarm_on || o_count_down))
        else $error("alarm raised in up mode");

    // A held result with a pending event stalls the input
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_stall) |-> o_stall)
        else $error("input not stalled with both registers full");

    // A processed event always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed event lost");

    // Hours tens digit stays within range
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_tens != 2'd3))
        else $error("hour tens out of range");
`endif

endmodule

FILE: design/bsct_core.sv
// Timer state registers and the per-event update logic.
module bsct_core import bsct_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_req   i_req,
    input  logic   i_hdown,
    output t_time  o_time,
    output t_flags o_flags
);

    t_time  r_time,  n_time;
    t_flags r_flags, n_flags;
    logic   adjust;
    logic   hours_zero;

    // Compute the state after one event
    always_comb begin
        n_time     = r_time;
        n_flags    = r_flags;
        adjust     = !r_flags.running && r_flags.down;
        hours_zero = (r_time.h1 == 4'd0) && (r_time.h10 == 2'd0);
        case (i_req)
            REQ_TICK: begin
                if (r_flags.running) begin
                    if (!r_flags.down) begin
                        n_time = is_24(r_time) ? time_24() : seconds_up(r_time);
                    end else if (is_zero(r_time)) begin
                        n_flags.alarm = 1'b1;
                    end else begin
                        n_time = seconds_down(r_time);
                    end
                end
            end
            REQ_CLEAR: begin
                n_time        = '0;
                n_flags.alarm = 1'b0;
            end
            REQ_PAUSE:  n_flags.running = 1'b0;
            REQ_RESUME: n_flags.running = 1'b1;
            REQ_TOGGLE: begin
                if (!r_flags.running) begin
                    n_flags.down = !r_flags.down;
                end
            end
            REQ_SEC_INC: begin
                if (adjust) begin
                    n_time = is_24(r_time) ? time_24() : seconds_up(r_time);
                end
            end
            REQ_SEC_DEC: begin
                if (adjust && !is_zero(r_time)) begin
                    n_time = seconds_down(r_time);
                end
            end
            REQ_MIN_INC: begin
                if (adjust) begin
                    if ((r_time.m1 == UNITS_MAX && r_time.m10 == TENS_MAX &&
                         r_time.h1 == HOUR1_LAST && r_time.h10 == HOUR10_TOP) ||
                        is_24(r_time)) begin
                        n_time = time_24();
                    end else begin
                        n_time = minutes_up(r_time);
                    end
                end
            end
            REQ_MIN_DEC: begin
                if (adjust && !(hours_zero && r_time.m1 == 4'd0 && r_time.m10 == 3'd0)) begin
                    n_time = minutes_down(r_time);
                end
            end
            REQ_HOUR_ADJ: begin
                if (adjust) begin
                    if (!i_hdown) begin
                        if (is_24(r_time) ||
                            (r_time.h1 == HOUR1_LAST && r_time.h10 == HOUR10_TOP)) begin
                            n_time = time_24();
                        end else begin
                            n_time = hours_up(r_time);
                        end
                    end else if (!hours_zero) begin
                        n_time = hours_down(r_time);
                    end
                end
            end
            default: ;
        endcase
        // Drop the alarm whenever counting up
        if (!n_flags.down) begin
            n_flags.alarm = 1'b0;
        end
    end

    // Hold state; advance on each processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time          <= '0;
            r_flags.running <= 1'b1;
            r_flags.down    <= 1'b0;
            r_flags.alarm   <= 1'b0;
        end else if (i_en) begin
            r_time  <= n_time;
            r_flags <= n_flags;
        end
    end

    assign o_time  = n_time;
    assign o_flags = n_flags;

endmodule
